@@ rtl/q2e_pkg.sv @@
// Shared constants, types and the arctangent table for the quaternion to Euler converter.
package q2e_pkg;

    localparam int unsigned TABLE_LEN = 24;
    localparam int unsigned VEC_W     = 36;
    localparam int unsigned ANG_W     = 33;
    localparam int unsigned RAD_W     = 58;
    localparam int unsigned ROOT_W    = 29;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [15:0]      PI_Q13      = 16'sd25736;
    localparam logic signed [14:0]      HALF_PI_Q13 = 15'sd12868;
    localparam logic signed [VEC_W-1:0] ONE_Q28     = 36'sd268435456;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    // One CORDIC lane: vector and accumulated angle.
    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } lane_t;

    // Square root state for the pitch cosine term.
    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    function automatic ang_t atan_entry(input logic [4:0] idx);
        ang_t r;
        begin
            unique case (idx)
                5'd0:    r = 33'sd843314857;
                5'd1:    r = 33'sd497837829;
                5'd2:    r = 33'sd263043837;
                5'd3:    r = 33'sd133525159;
                5'd4:    r = 33'sd67021688;
                5'd5:    r = 33'sd33543516;
                5'd6:    r = 33'sd16775851;
                5'd7:    r = 33'sd8388437;
                5'd8:    r = 33'sd4194283;
                5'd9:    r = 33'sd2097149;
                5'd10:   r = 33'sd1048576;
                5'd11:   r = 33'sd524288;
                5'd12:   r = 33'sd262144;
                5'd13:   r = 33'sd131072;
                5'd14:   r = 33'sd65536;
                5'd15:   r = 33'sd32768;
                5'd16:   r = 33'sd16384;
                5'd17:   r = 33'sd8192;
                5'd18:   r = 33'sd4096;
                5'd19:   r = 33'sd2048;
                5'd20:   r = 33'sd1024;
                5'd21:   r = 33'sd512;
                5'd22:   r = 33'sd256;
                5'd23:   r = 33'sd128;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Pre-rotation into the right half plane, then Q30 seed angle.
    function automatic lane_t pre_rotate(input vec_t x, input vec_t y);
        lane_t r;
        begin
            r.x = x;
            r.y = y;
            r.z = '0;
            if (x < 0) begin
                if (y >= 0) begin
                    r.x = y;
                    r.y = -x;
                    r.z = HALF_PI_Q30;
                end
                else begin
                    r.x = -y;
                    r.y = x;
                    r.z = -HALF_PI_Q30;
                end
            end
            return r;
        end
    endfunction

    // Q30 angle to Q13 with rounding, clamped to +/-lim.
    function automatic logic signed [15:0] q30_to_q13(input ang_t a,
                                                      input logic signed [15:0] lim);
        logic signed [ANG_W:0] s;
        logic signed [ANG_W-17:0] q;
        logic signed [15:0] r;
        begin
            s = {a[ANG_W-1], a} + (ANG_W+1)'(65536);
            q = s[ANG_W:17];
            if (q > (ANG_W-16)'(lim))
                r = lim;
            else if (q < -(ANG_W-16)'(lim))
                r = -lim;
            else
                r = q[15:0];
            return r;
        end
    endfunction

endpackage

@@ rtl/q2e_cordic_cell.sv @@
// One vectoring CORDIC cell: a fixed shift and table angle, one register stage.
module q2e_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic           clk,
    input  q2e_pkg::lane_t lane_in,
    output q2e_pkg::lane_t lane_out
);

    q2e_pkg::lane_t lane_reg;
    q2e_pkg::lane_t lane_next;

    always_comb
    begin
        lane_next = lane_in;
        if (lane_in.y >= 0) begin
            lane_next.x = lane_in.x + (lane_in.y >>> STEP);
            lane_next.y = lane_in.y - (lane_in.x >>> STEP);
            lane_next.z = lane_in.z + q2e_pkg::atan_entry(5'(STEP));
        end
        else begin
            lane_next.x = lane_in.x - (lane_in.y >>> STEP);
            lane_next.y = lane_in.y + (lane_in.x >>> STEP);
            lane_next.z = lane_in.z - q2e_pkg::atan_entry(5'(STEP));
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

@@ rtl/q2e_sqrt_cell.sv @@
// One restoring square root cell: one result bit per stage.
module q2e_sqrt_cell #(
    parameter int unsigned BITPOS = 0
) (
    input  logic           clk,
    input  q2e_pkg::sqrt_t sq_in,
    output q2e_pkg::sqrt_t sq_out
);

    localparam int unsigned RW = q2e_pkg::RAD_W;

    q2e_pkg::sqrt_t sq_reg;
    q2e_pkg::sqrt_t sq_next;
    logic [RW:0]    trial;

    // root holds root bits aligned as in the classic bit-pair method.
    always_comb
    begin
        trial   = {1'b0, RW'(sq_in.root) << (BITPOS + 1)} + ((RW + 1)'(1) << (2 * BITPOS));
        sq_next = sq_in;
        if ({1'b0, sq_in.rem} >= trial) begin
            sq_next.rem  = sq_in.rem - trial[RW-1:0];
            sq_next.root = sq_in.root | (q2e_pkg::ROOT_W'(1) << BITPOS);
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign sq_out = sq_reg;

endmodule

@@ rtl/quaternion_to_euler_angles.sv @@
// Top level: quaternion to roll, pitch and yaw through chains of CORDIC and root cells.
// Pipeline: products, sums, 29 root cells, pitch pre-rotation, then CORDIC_STEPS cells (capped
// at TABLE_LEN) and the output register; roll/yaw are delayed to line up with pitch.
// Throughput: one transaction per cycle; busy is always low, every cell advances each cycle.
// Reset: rst_n clears only the valid bits; data registers carry no reset.
// The receiver cannot stall; done strobes for one cycle with the result ports.
module quaternion_to_euler_angles #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               done,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_saturated
);

    localparam int unsigned NSTEP  = (CORDIC_STEPS < q2e_pkg::TABLE_LEN) ?
                                     CORDIC_STEPS : q2e_pkg::TABLE_LEN;
    localparam int unsigned RW     = q2e_pkg::ROOT_W;
    // pitch waits for root stages plus pre-rotation; roll/yaw are delayed to match
    localparam int unsigned PDLY   = RW + 1;
    localparam int unsigned TOTAL  = 2 + PDLY + NSTEP + 1;

    typedef logic signed [35:0] v36_t;

    assign busy = 1'b0;

    // ---- stage 1: products in Q2.28 (one multiplier per term) ----
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;

    always_ff @(posedge clk)
    begin
        p_wx_reg <= quat_w * quat_x;
        p_yz_reg <= quat_y * quat_z;
        p_xx_reg <= quat_x * quat_x;
        p_yy_reg <= quat_y * quat_y;
        p_wy_reg <= quat_w * quat_y;
        p_zx_reg <= quat_z * quat_x;
        p_wz_reg <= quat_w * quat_z;
        p_xy_reg <= quat_x * quat_y;
        p_zz_reg <= quat_z * quat_z;
    end

    // ---- stage 2: sums, pre-rotation, pitch limit check ----
    v36_t sr, cr, sp, sy, cy;
    assign sr = (v36_t'(p_wx_reg) + v36_t'(p_yz_reg)) <<< 1;
    assign cr = q2e_pkg::ONE_Q28 - ((v36_t'(p_xx_reg) + v36_t'(p_yy_reg)) <<< 1);
    assign sp = (v36_t'(p_wy_reg) - v36_t'(p_zx_reg)) <<< 1;
    assign sy = (v36_t'(p_wz_reg) + v36_t'(p_xy_reg)) <<< 1;
    assign cy = q2e_pkg::ONE_Q28 - ((v36_t'(p_yy_reg) + v36_t'(p_zz_reg)) <<< 1);

    q2e_pkg::lane_t roll_lane_reg, yaw_lane_reg;
    logic roll_zero_reg, yaw_zero_reg;
    logic signed [29:0] sp_reg;
    logic sat_reg, sp_pos_reg;
    logic [57:0] rad_next;
    logic [57:0] rad_reg;
    logic [59:0] sp_sq;
    logic [29:0] sp_mag;

    // for |sp| < 2^28 the square fits 56 bits; sp_mag is 30 bits wide, a 30x30 multiply
    assign sp_mag = sp[35] ? 30'(-sp) : sp[29:0];
    assign sp_sq  = {30'd0, sp_mag} * {30'd0, sp_mag};

    always_ff @(posedge clk)
    begin
        roll_lane_reg <= q2e_pkg::pre_rotate(cr, sr);
        yaw_lane_reg  <= q2e_pkg::pre_rotate(cy, sy);
        roll_zero_reg <= (sr == 0) && (cr == 0);
        yaw_zero_reg  <= (sy == 0) && (cy == 0);
        sat_reg       <= (sp >= q2e_pkg::ONE_Q28) || (sp <= -q2e_pkg::ONE_Q28);
        sp_pos_reg    <= sp > 0;
        sp_reg        <= sp[29:0];
        rad_reg       <= rad_next;
    end

    // pre_rotate above takes (x, y) = (cos, sin)
    q2e_pkg::lane_t roll_seed, yaw_seed;
    always_comb
    begin
        roll_seed = roll_lane_reg;
        yaw_seed  = yaw_lane_reg;
    end

    // ---- pitch radicand: root chain, one bit per cell ----
    q2e_pkg::sqrt_t sq_chain [0:RW];
    logic signed [29:0] sp_dly   [0:RW];
    logic               sat_dly  [0:RW];
    logic               pos_dly  [0:RW];

    always_comb
    begin
        rad_next = (58'd1 << 56) - sp_sq[57:0];
    end

    // radicand is registered with sp so both enter their chains on the same cycle
    assign sq_chain[0].rem  = rad_reg;
    assign sq_chain[0].root = '0;
    assign sp_dly[0]  = sp_reg;
    assign sat_dly[0] = sat_reg;
    assign pos_dly[0] = sp_pos_reg;

    genvar g;
    generate
        for (g = 0; g < RW; g = g + 1) begin : g_sqrt
            q2e_sqrt_cell #(.BITPOS(RW - 1 - g)) u_cell (
                .clk    (clk),
                .sq_in  (sq_chain[g]),
                .sq_out (sq_chain[g+1])
            );
            always_ff @(posedge clk)
            begin
                sp_dly[g+1]  <= sp_dly[g];
                sat_dly[g+1] <= sat_dly[g];
                pos_dly[g+1] <= pos_dly[g];
            end
        end
    endgenerate

    // ---- pitch pre-rotation stage ----
    q2e_pkg::lane_t pitch_lane_reg;
    logic pitch_zero_reg, psat_reg, ppos_reg;
    v36_t c36, s36;
    assign c36 = v36_t'({7'd0, sq_chain[RW].root});
    assign s36 = v36_t'(sp_dly[RW]);

    always_ff @(posedge clk)
    begin
        pitch_lane_reg <= q2e_pkg::pre_rotate(c36, s36);
        pitch_zero_reg <= (c36 == 0) && (s36 == 0);
        psat_reg       <= sat_dly[RW];
        ppos_reg       <= pos_dly[RW];
    end

    // ---- delay roll/yaw seeds to line up with pitch ----
    q2e_pkg::lane_t ry_roll [0:PDLY];
    q2e_pkg::lane_t ry_yaw  [0:PDLY];
    logic           rz_roll [0:PDLY];
    logic           rz_yaw  [0:PDLY];
    assign ry_roll[0] = roll_seed;
    assign ry_yaw[0]  = yaw_seed;
    assign rz_roll[0] = roll_zero_reg;
    assign rz_yaw[0]  = yaw_zero_reg;

    generate
        for (g = 0; g < PDLY; g = g + 1) begin : g_align
            always_ff @(posedge clk)
            begin
                ry_roll[g+1] <= ry_roll[g];
                ry_yaw[g+1]  <= ry_yaw[g];
                rz_roll[g+1] <= rz_roll[g];
                rz_yaw[g+1]  <= rz_yaw[g];
            end
        end
    endgenerate

    // ---- three CORDIC chains ----
    q2e_pkg::lane_t c_roll  [0:NSTEP];
    q2e_pkg::lane_t c_yaw   [0:NSTEP];
    q2e_pkg::lane_t c_pitch [0:NSTEP];
    logic zr [0:NSTEP];
    logic zy [0:NSTEP];
    logic zp [0:NSTEP];
    logic st [0:NSTEP];
    logic ps [0:NSTEP];

    assign c_roll[0]  = ry_roll[PDLY];
    assign c_yaw[0]   = ry_yaw[PDLY];
    assign c_pitch[0] = pitch_lane_reg;
    assign zr[0] = rz_roll[PDLY];
    assign zy[0] = rz_yaw[PDLY];
    assign zp[0] = pitch_zero_reg;
    assign st[0] = psat_reg;
    assign ps[0] = ppos_reg;

    generate
        for (g = 0; g < NSTEP; g = g + 1) begin : g_cordic
            q2e_cordic_cell #(.STEP(g)) u_roll (
                .clk(clk), .lane_in(c_roll[g]), .lane_out(c_roll[g+1]));
            q2e_cordic_cell #(.STEP(g)) u_yaw (
                .clk(clk), .lane_in(c_yaw[g]), .lane_out(c_yaw[g+1]));
            q2e_cordic_cell #(.STEP(g)) u_pitch (
                .clk(clk), .lane_in(c_pitch[g]), .lane_out(c_pitch[g+1]));
            always_ff @(posedge clk)
            begin
                zr[g+1] <= zr[g];
                zy[g+1] <= zy[g];
                zp[g+1] <= zp[g];
                st[g+1] <= st[g];
                ps[g+1] <= ps[g];
            end
        end
    endgenerate

    // ---- output stage ----
    logic signed [15:0] roll_reg, yaw_reg, pitch16;
    logic signed [14:0] pitch_reg;
    logic               sat_out_reg;

    assign pitch16 = q2e_pkg::q30_to_q13(c_pitch[NSTEP].z, 16'(q2e_pkg::HALF_PI_Q13));

    always_ff @(posedge clk)
    begin
        roll_reg <= zr[NSTEP] ? 16'sd0 : q2e_pkg::q30_to_q13(c_roll[NSTEP].z, q2e_pkg::PI_Q13);
        yaw_reg  <= zy[NSTEP] ? 16'sd0 : q2e_pkg::q30_to_q13(c_yaw[NSTEP].z, q2e_pkg::PI_Q13);
        if (st[NSTEP])
            pitch_reg <= ps[NSTEP] ? q2e_pkg::HALF_PI_Q13 : -q2e_pkg::HALF_PI_Q13;
        else if (zp[NSTEP])
            pitch_reg <= '0;
        else
            pitch_reg <= pitch16[14:0];
        sat_out_reg <= st[NSTEP];
    end

    // transaction valid tracking
    logic [TOTAL-1:0] vld_reg;
    logic [TOTAL-1:0] vld_next;
    assign vld_next = {vld_reg[TOTAL-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done            = vld_reg[TOTAL-1];
    assign roll_angle      = roll_reg;
    assign yaw_angle       = yaw_reg;
    assign pitch_angle     = pitch_reg;
    assign pitch_saturated = sat_out_reg;

endmodule
